// ===== rtl/core/sul_pkg.sv =====
// ----------------------------------------------------------------------------
// sul_pkg
// Shared constants, request codes and types for the sorted unique list.
// ----------------------------------------------------------------------------
`default_nettype none

package sul_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int REQ_W    = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef struct packed {
    logic ins;
    logic rem;
  } sul_upd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sul_cell.sv =====
// ----------------------------------------------------------------------------
// sul_cell
// One slot of the list: holds an entry, compares it with the probe value and
// shifts toward its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_cell (
  input  logic                                clk,
  input  logic                                cmp_en,
  input  logic                                occupied,
  input  logic signed [sul_pkg::DATA_W-1:0]   probe,
  input  logic signed [sul_pkg::DATA_W-1:0]   new_value,
  input  logic                                left_lt,
  input  logic signed [sul_pkg::DATA_W-1:0]   left_value,
  input  logic signed [sul_pkg::DATA_W-1:0]   right_value,
  input  sul_pkg::sul_upd_t                   upd,
  output logic signed [sul_pkg::DATA_W-1:0]   value,
  output logic                                lt,
  output logic                                eq
);
  import sul_pkg::*;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= occupied && (value < probe);
      eq <= occupied && (value == probe);
    end
    if (upd.ins && !lt) begin
      value <= left_lt ? new_value : left_value;
    end else if (upd.rem && !lt) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_unique_list.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_list
// Fixed-capacity set of signed values kept in ascending order in a row of
// cells, with insert, remove, search, read at index and clear requests.
// ----------------------------------------------------------------------------
// Flow: in ST_IDLE a request is taken and all cells compare against its value;
// in ST_EXEC the row shifts and the result registers load. No new request is
// taken during ST_EXEC or while a result waits under rsp_stall.
// Reset clears the count and both handshakes; entries are undefined until written.
`default_nettype none

module sorted_unique_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [sul_pkg::REQ_W-1:0]         req_type,
  input  logic signed [sul_pkg::DATA_W-1:0] item_value,
  input  logic [sul_pkg::IDX_W-1:0]         position,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              success,
  output logic [sul_pkg::IDX_W-1:0]         found_index,
  output logic signed [sul_pkg::DATA_W-1:0] read_value,
  output logic [sul_pkg::CNT_W-1:0]         entry_count,
  output logic                              is_full,
  output logic                              is_empty
);
  import sul_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                    st;
  logic [CNT_W-1:0]        count;
  logic [REQ_W-1:0]        r_type;
  logic signed [DATA_W-1:0] r_value;
  logic [IDX_W-1:0]        r_pos;

  logic                    accept;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     edge_bit;
  logic [IDX_W-1:0]        lb_idx;
  logic                    hit;
  logic                    full;
  sul_upd_t                upd;
  sul_upd_t                upd_gated;

  logic                    success_next;
  logic [IDX_W-1:0]        found_index_next;
  logic signed [DATA_W-1:0] read_value_next;
  logic [CNT_W-1:0]        count_next;

  assign req_stall = (st == ST_EXEC) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  genvar j;
  generate
    for (j = 0; j < CAPACITY; j++) begin : g_cell
      logic                    left_lt;
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;
      if (j == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_value = r_value;
      end else begin : g_inner
        assign left_lt    = cell_lt[j-1];
        assign left_value = cell_value[j-1];
      end
      if (j == CAPACITY - 1) begin : g_last
        assign right_value = cell_value[j];
      end else begin : g_mid
        assign right_value = cell_value[j+1];
      end
      assign edge_bit[j] = !cell_lt[j] && left_lt;

      sul_cell u_cell (
        .clk         (clk),
        .cmp_en      (accept),
        .occupied    (CNT_W'(j) < count),
        .probe       (item_value),
        .new_value   (r_value),
        .left_lt     (left_lt),
        .left_value  (left_value),
        .right_value (right_value),
        .upd         (upd_gated),
        .value       (cell_value[j]),
        .lt          (cell_lt[j]),
        .eq          (cell_eq[j])
      );
    end
  endgenerate

  always_comb begin
    lb_idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      lb_idx = lb_idx | (IDX_W'(k) & {IDX_W{edge_bit[k]}});
    end
  end

  assign hit  = |cell_eq;
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    upd              = '0;
    success_next     = 1'b0;
    found_index_next = '0;
    read_value_next  = '0;
    count_next       = count;
    case (r_type)
      REQ_INSERT: begin
        if (!full) begin
          found_index_next = lb_idx;
          if (!hit) begin
            upd.ins      = 1'b1;
            success_next = 1'b1;
            count_next   = count + 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          upd.rem          = 1'b1;
          success_next     = 1'b1;
          found_index_next = lb_idx;
          count_next       = count - 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (hit) begin
          success_next     = 1'b1;
          found_index_next = lb_idx;
        end
      end
      REQ_READ: begin
        if ({1'b0, r_pos} < count) begin
          success_next     = 1'b1;
          found_index_next = r_pos;
          read_value_next  = cell_value[r_pos];
        end
      end
      REQ_CLEAR: begin
        success_next = 1'b1;
        count_next   = '0;
      end
      default: begin
      end
    endcase
  end

  assign upd_gated = (st == ST_EXEC) ? upd : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      r_type  <= req_type;
      r_value <= item_value;
      r_pos   <= position;
    end
    if (st == ST_EXEC) begin
      success     <= success_next;
      found_index <= found_index_next;
      read_value  <= read_value_next;
      entry_count <= count_next;
      is_full     <= (count_next == CNT_W'(CAPACITY));
      is_empty    <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
          if (accept) begin
            st <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count     <= count_next;
          rsp_valid <= 1'b1;
          st        <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sul_checker.sv =====
// ----------------------------------------------------------------------------
// sul_checker
// Port-level checks for the sorted unique list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_stall,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input logic                              success,
  input logic [sul_pkg::IDX_W-1:0]         found_index,
  input logic signed [sul_pkg::DATA_W-1:0] read_value,
  input logic [sul_pkg::CNT_W-1:0]         entry_count,
  input logic                              is_full,
  input logic                              is_empty
);
  import sul_pkg::*;

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(success) && $stable(found_index)
      && $stable(read_value) && $stable(entry_count))
    else $error("stalled result changed");

  // The flags agree with the reported count, which never exceeds capacity.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= CNT_W'(CAPACITY))
      && (is_full == (entry_count == CNT_W'(CAPACITY)))
      && (is_empty == (entry_count == '0)))
    else $error("count flags inconsistent");

  // A nonzero read value only comes with a successful read.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (read_value != '0) |-> success)
    else $error("read value without success");

  // A request transaction is never taken while a result waits under stall.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("request taken while result stalled");

  // While a taken request executes in ST_EXEC, no result is valid.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !rsp_valid)
    else $error("result appeared one cycle after request");

endmodule

bind sorted_unique_list sul_checker u_sul_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .success     (success),
  .found_index (found_index),
  .read_value  (read_value),
  .entry_count (entry_count),
  .is_full     (is_full),
  .is_empty    (is_empty)
);

`default_nettype wire
